// ===== hdl/c8dx_pkg.sv =====
// Shared types and opcode field codes for the 8-bit decode/execute unit.
package c8dx_pkg;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [7:0] wd;
    logic       we;
    logic [7:0] pd;
    logic       pe;
    logic       br;
    logic       bad;
  } effects_t;

  localparam regs_t REGS_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFD, p: 8'h24};

  // status bit positions, NV1BDIZC
  localparam logic [2:0] PB_C = 3'd0;
  localparam logic [2:0] PB_Z = 3'd1;
  localparam logic [2:0] PB_I = 3'd2;
  localparam logic [2:0] PB_D = 3'd3;
  localparam logic [2:0] PB_B = 3'd4;
  localparam logic [2:0] PB_U = 3'd5;
  localparam logic [2:0] PB_V = 3'd6;
  localparam logic [2:0] PB_N = 3'd7;

  // cc groups
  localparam logic [1:0] CC_CTL = 2'd0;
  localparam logic [1:0] CC_ALU = 2'd1;
  localparam logic [1:0] CC_RMW = 2'd2;

  // bbb addressing codes
  localparam logic [2:0] BBB_IMM    = 3'd0;
  localparam logic [2:0] BBB_ZP     = 3'd1;
  localparam logic [2:0] BBB_IMP    = 3'd2;
  localparam logic [2:0] BBB_ABS    = 3'd3;
  localparam logic [2:0] BBB_BRANCH = 3'd4;
  localparam logic [2:0] BBB_ZPX    = 3'd5;
  localparam logic [2:0] BBB_FLAG   = 3'd6;

  // aaa codes, cc = 1
  localparam logic [2:0] ALU_ORA = 3'd0;
  localparam logic [2:0] ALU_AND = 3'd1;
  localparam logic [2:0] ALU_EOR = 3'd2;
  localparam logic [2:0] ALU_ADC = 3'd3;
  localparam logic [2:0] ALU_STA = 3'd4;
  localparam logic [2:0] ALU_LDA = 3'd5;
  localparam logic [2:0] ALU_CMP = 3'd6;
  localparam logic [2:0] ALU_SBC = 3'd7;

  // aaa codes, cc = 2
  localparam logic [2:0] RMW_ASL = 3'd0;
  localparam logic [2:0] RMW_ROL = 3'd1;
  localparam logic [2:0] RMW_LSR = 3'd2;
  localparam logic [2:0] RMW_ROR = 3'd3;
  localparam logic [2:0] RMW_STX = 3'd4;
  localparam logic [2:0] RMW_LDX = 3'd5;
  localparam logic [2:0] RMW_DEC = 3'd6;
  localparam logic [2:0] RMW_INC = 3'd7;

  // aaa codes, cc = 0, implied stack/index group
  localparam logic [2:0] IMP_PHP = 3'd0;
  localparam logic [2:0] IMP_PLP = 3'd1;
  localparam logic [2:0] IMP_PHA = 3'd2;
  localparam logic [2:0] IMP_PLA = 3'd3;
  localparam logic [2:0] IMP_DEY = 3'd4;
  localparam logic [2:0] IMP_TAY = 3'd5;
  localparam logic [2:0] IMP_INY = 3'd6;
  localparam logic [2:0] IMP_INX = 3'd7;

  // aaa codes, cc = 0, flag group
  localparam logic [2:0] FLG_CLC = 3'd0;
  localparam logic [2:0] FLG_SEC = 3'd1;
  localparam logic [2:0] FLG_CLI = 3'd2;
  localparam logic [2:0] FLG_SEI = 3'd3;
  localparam logic [2:0] FLG_TYA = 3'd4;
  localparam logic [2:0] FLG_CLV = 3'd5;
  localparam logic [2:0] FLG_CLD = 3'd6;
  localparam logic [2:0] FLG_SED = 3'd7;

  // aaa codes, cc = 0, memory group
  localparam logic [2:0] CTL_BIT = 3'd1;
  localparam logic [2:0] CTL_STY = 3'd4;
  localparam logic [2:0] CTL_LDY = 3'd5;
  localparam logic [2:0] CTL_CPY = 3'd6;
  localparam logic [2:0] CTL_CPX = 3'd7;

  // branch flag selector, aaa[2:1]
  localparam logic [1:0] BRS_N = 2'd0;
  localparam logic [1:0] BRS_V = 2'd1;
  localparam logic [1:0] BRS_C = 2'd2;

endpackage

// ===== hdl/c8dx_exec.sv =====
// Opcode decode and combinational execute on the register file.
module c8dx_exec (
  input  logic [7:0]        op_i,
  input  logic [7:0]        opd_i,
  input  logic [7:0]        sb_i,
  input  c8dx_pkg::regs_t    regs_i,
  output c8dx_pkg::regs_t    regs_o,
  output c8dx_pkg::effects_t eff_o
);
  import c8dx_pkg::*;

  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r       = p;
    r[PB_Z] = (v == 8'h00);
    r[PB_N] = v[7];
    return r;
  endfunction

  function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] r,
                                           input logic [7:0] m);
    logic [8:0] diff;
    logic [7:0] q;
    diff    = {1'b0, r} - {1'b0, m};
    q       = set_zn(p, diff[7:0]);
    q[PB_C] = ~diff[8];
    return q;
  endfunction

  // returns {carry out, result}
  function automatic logic [8:0] shifter(input logic [2:0] kind, input logic [7:0] v,
                                         input logic cin);
    logic [8:0] r;
    case (kind)
      RMW_ASL: r = {v[7], v[6:0], 1'b0};
      RMW_ROL: r = {v[7], v[6:0], cin};
      RMW_LSR: r = {v[0], 1'b0, v[7:1]};
      RMW_ROR: r = {v[0], cin, v[7:1]};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

  logic [2:0] aaa;
  logic [2:0] bbb;
  logic [1:0] cc;
  logic       memmode;
  logic [7:0] am;
  logic [8:0] sum;
  logic       ovf;
  logic [8:0] sh_m;
  logic [8:0] sh_a;
  logic [7:0] incdec;
  logic       bflag;
  regs_t      r;
  effects_t   e;

  assign aaa     = op_i[7:5];
  assign bbb     = op_i[4:2];
  assign cc      = op_i[1:0];
  assign memmode = bbb[0];

  assign am     = (aaa == ALU_SBC) ? ~opd_i : opd_i;
  assign sum    = {1'b0, regs_i.a} + {1'b0, am} + {8'd0, regs_i.p[PB_C]};
  assign ovf    = ~(regs_i.a[7] ^ am[7]) & (regs_i.a[7] ^ sum[7]);
  assign sh_m   = shifter(aaa, opd_i, regs_i.p[PB_C]);
  assign sh_a   = shifter(aaa, regs_i.a, regs_i.p[PB_C]);
  assign incdec = (aaa == RMW_DEC) ? opd_i - 8'd1 : opd_i + 8'd1;

  always_comb begin
    case (aaa[2:1])
      BRS_N:   bflag = regs_i.p[PB_N];
      BRS_V:   bflag = regs_i.p[PB_V];
      BRS_C:   bflag = regs_i.p[PB_C];
      default: bflag = regs_i.p[PB_Z];
    endcase
  end

  always_comb begin
    r = regs_i;
    e = '0;
    case (cc)
      CC_ALU: begin
        case (aaa)
          ALU_ORA: begin
            r.a = regs_i.a | opd_i;
            r.p = set_zn(regs_i.p, r.a);
          end
          ALU_AND: begin
            r.a = regs_i.a & opd_i;
            r.p = set_zn(regs_i.p, r.a);
          end
          ALU_EOR: begin
            r.a = regs_i.a ^ opd_i;
            r.p = set_zn(regs_i.p, r.a);
          end
          ALU_ADC, ALU_SBC: begin
            r.a       = sum[7:0];
            r.p       = set_zn(regs_i.p, sum[7:0]);
            r.p[PB_C] = sum[8];
            r.p[PB_V] = ovf;
          end
          ALU_STA: begin
            if (bbb == BBB_IMP) begin
              e.bad = 1'b1;
            end else begin
              e.wd = regs_i.a;
              e.we = 1'b1;
            end
          end
          ALU_LDA: begin
            r.a = opd_i;
            r.p = set_zn(regs_i.p, opd_i);
          end
          ALU_CMP: r.p = cmp_flags(regs_i.p, regs_i.a, opd_i);
          default: e.bad = 1'b1;
        endcase
      end
      CC_RMW: begin
        case (aaa)
          RMW_ASL, RMW_ROL, RMW_LSR, RMW_ROR: begin
            if (memmode) begin
              e.wd      = sh_m[7:0];
              e.we      = 1'b1;
              r.p       = set_zn(regs_i.p, sh_m[7:0]);
              r.p[PB_C] = sh_m[8];
            end else if (bbb == BBB_IMP) begin
              r.a       = sh_a[7:0];
              r.p       = set_zn(regs_i.p, sh_a[7:0]);
              r.p[PB_C] = sh_a[8];
            end else begin
              e.bad = 1'b1;
            end
          end
          RMW_STX: begin
            if (bbb inside {BBB_ZP, BBB_ABS, BBB_ZPX}) begin
              e.wd = regs_i.x;
              e.we = 1'b1;
            end else if (bbb == BBB_IMP) begin
              r.a = regs_i.x;
              r.p = set_zn(regs_i.p, regs_i.x);
            end else if (bbb == BBB_FLAG) begin
              r.sp = regs_i.x;
            end else begin
              e.bad = 1'b1;
            end
          end
          RMW_LDX: begin
            if (bbb == BBB_IMM || memmode) begin
              r.x = opd_i;
              r.p = set_zn(regs_i.p, opd_i);
            end else if (bbb == BBB_IMP) begin
              r.x = regs_i.a;
              r.p = set_zn(regs_i.p, regs_i.a);
            end else if (bbb == BBB_FLAG) begin
              r.x = regs_i.sp;
              r.p = set_zn(regs_i.p, regs_i.sp);
            end else begin
              e.bad = 1'b1;
            end
          end
          default: begin
            if (memmode) begin
              e.wd = incdec;
              e.we = 1'b1;
              r.p  = set_zn(regs_i.p, incdec);
            end else if (bbb == BBB_IMP) begin
              if (aaa == RMW_DEC) begin
                r.x = regs_i.x - 8'd1;
                r.p = set_zn(regs_i.p, r.x);
              end
            end else begin
              e.bad = 1'b1;
            end
          end
        endcase
      end
      CC_CTL: begin
        if (bbb == BBB_BRANCH) begin
          e.br = (bflag == aaa[0]);
        end else if (bbb == BBB_IMP) begin
          case (aaa)
            IMP_PHP: begin
              e.pd       = regs_i.p;
              e.pd[PB_B] = 1'b1;
              e.pd[PB_U] = 1'b1;
              e.pe       = 1'b1;
              r.sp       = regs_i.sp - 8'd1;
            end
            IMP_PLP: begin
              r.p       = sb_i;
              r.p[PB_B] = 1'b0;
              r.p[PB_U] = 1'b1;
              r.sp      = regs_i.sp + 8'd1;
            end
            IMP_PHA: begin
              e.pd = regs_i.a;
              e.pe = 1'b1;
              r.sp = regs_i.sp - 8'd1;
            end
            IMP_PLA: begin
              r.a  = sb_i;
              r.p  = set_zn(regs_i.p, sb_i);
              r.sp = regs_i.sp + 8'd1;
            end
            IMP_DEY: begin
              r.y = regs_i.y - 8'd1;
              r.p = set_zn(regs_i.p, r.y);
            end
            IMP_TAY: begin
              r.y = regs_i.a;
              r.p = set_zn(regs_i.p, regs_i.a);
            end
            IMP_INY: begin
              r.y = regs_i.y + 8'd1;
              r.p = set_zn(regs_i.p, r.y);
            end
            default: begin
              r.x = regs_i.x + 8'd1;
              r.p = set_zn(regs_i.p, r.x);
            end
          endcase
        end else if (bbb == BBB_FLAG) begin
          case (aaa)
            FLG_CLC: r.p[PB_C] = 1'b0;
            FLG_SEC: r.p[PB_C] = 1'b1;
            FLG_CLI: r.p[PB_I] = 1'b0;
            FLG_SEI: r.p[PB_I] = 1'b1;
            FLG_TYA: begin
              r.a = regs_i.y;
              r.p = set_zn(regs_i.p, regs_i.y);
            end
            FLG_CLV: r.p[PB_V] = 1'b0;
            FLG_CLD: r.p[PB_D] = 1'b0;
            default: r.p[PB_D] = 1'b1;
          endcase
        end else if (aaa == CTL_BIT && (bbb == BBB_ZP || bbb == BBB_ABS)) begin
          r.p[PB_Z] = ((regs_i.a & opd_i) == 8'h00);
          r.p[PB_V] = opd_i[6];
          r.p[PB_N] = opd_i[7];
        end else if (aaa == CTL_STY && (bbb inside {BBB_ZP, BBB_ABS, BBB_ZPX})) begin
          e.wd = regs_i.y;
          e.we = 1'b1;
        end else if (aaa == CTL_LDY && (bbb == BBB_IMM || memmode)) begin
          r.y = opd_i;
          r.p = set_zn(regs_i.p, opd_i);
        end else if (aaa == CTL_CPY && (bbb inside {BBB_IMM, BBB_ZP, BBB_ABS})) begin
          r.p = cmp_flags(regs_i.p, regs_i.y, opd_i);
        end else if (aaa == CTL_CPX && (bbb inside {BBB_IMM, BBB_ZP, BBB_ABS})) begin
          r.p = cmp_flags(regs_i.p, regs_i.x, opd_i);
        end else begin
          e.bad = 1'b1;
        end
      end
      default: e.bad = 1'b1;
    endcase
  end

  assign regs_o = r;
  assign eff_o  = e;

endmodule

// ===== hdl/cpu_8bit_decode_execute_unit.sv =====
// Top level of the 8-bit decode/execute unit with stream handshakes.
// Executes one official 6502 opcode per request on the kept A, X, Y, SP and
// status registers (binary ADC/SBC only; BRK, JSR, RTI, RTS and JMP report
// unsupported with state unchanged). A request is taken every cycle when the
// result side keeps up. It is held in the input register while the execute
// logic works on it; its result is then loaded into the result register and
// presented from there. The sustained rate of one request per cycle is set
// by the register file feedback through the combinational execute path.
// While a result is stalled the input register takes one more request and
// then holds it until the result is taken. Register outputs show the state
// after the request whose result is presented.
module cpu_8bit_decode_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // operand[7:0], stack_byte[15:8]
  input  logic [7:0]  s_axis_tuser,  // req_type[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // write_data[7:0], write_enable[8], push_data[16:9],
                                     // push_enable[17], branch_taken[18], acc_out[26:19],
                                     // xreg_out[34:27], yreg_out[42:35], sp_out[50:43],
                                     // status_out[58:51], zero[63:59]
  output logic        m_axis_tuser   // unsupported[0]
);
  import c8dx_pkg::*;

  logic       in_vld_q;
  logic [7:0] op_q;
  logic [7:0] opd_q;
  logic [7:0] sb_q;
  logic       out_vld_q;
  effects_t   eff_q;
  effects_t   eff_d;
  regs_t      regs_q;
  regs_t      regs_d;
  logic       advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      opd_q <= s_axis_tdata[7:0];
      sb_q  <= s_axis_tdata[15:8];
    end
  end

  c8dx_exec u_exec (
    .op_i   (op_q),
    .opd_i  (opd_q),
    .sb_i   (sb_q),
    .regs_i (regs_q),
    .regs_o (regs_d),
    .eff_o  (eff_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q    <= REGS_RESET;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      regs_q    <= regs_d;
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      eff_q <= eff_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, regs_q.p, regs_q.sp, regs_q.y, regs_q.x, regs_q.a,
                          eff_q.br, eff_q.pe, eff_q.pd, eff_q.we, eff_q.wd};
  assign m_axis_tuser  = eff_q.bad;

endmodule

// ===== hdl/c8dx_checker.sv =====
// Port-level checks for the decode/execute unit and their binding.
module c8dx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18:0] == 19'd0)
    else $error("unsupported opcode produced side effects");

  a_status_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[56] && !m_axis_tdata[55])
    else $error("status bit 5 or B flag wrong");

  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[17]) &&
                      !(m_axis_tdata[8] && m_axis_tdata[18]) &&
                      !(m_axis_tdata[17] && m_axis_tdata[18]))
    else $error("more than one of write, push and branch");

endmodule

bind cpu_8bit_decode_execute_unit c8dx_checker u_c8dx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb.sv =====
// Testbench for cpu_8bit_decode_execute_unit: random opcode requests checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import c8dx_pkg::*;

  localparam logic [2:0] BBB_ALU_IMM = 3'd2;
  localparam logic [2:0] BBB_ABS_X = 3'd7;
  localparam logic [1:0] CC_ILL = 2'd3;
  localparam logic [2:0] BR_ON_V_CLEAR = 3'd2;
  localparam logic [2:0] BR_ON_V_SET = 3'd3;
  localparam logic [7:0] OPC_BRK = 8'h00;
  localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
  localparam int unsigned N_RANDOM = 1200;
  localparam int unsigned DRAIN_AT = 600;
  localparam int unsigned HOLD_AT = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct packed {
    effects_t fx;
    regs_t    rg;
  } exec_result_t;

  typedef struct {
    logic [7:0] op;
    logic [7:0] m;
    logic [7:0] sb;
    bit         drain;
  } exec_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // operand[7:0], stack_byte[15:8]
  logic [7:0]  s_axis_tuser = '0;  // req_type[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // write_data[7:0], write_enable[8], push_data[16:9],
                                   // push_enable[17], branch_taken[18], acc_out[26:19],
                                   // xreg_out[34:27], yreg_out[42:35], sp_out[50:43],
                                   // status_out[58:51], zero[63:59]
  logic        m_axis_tuser;       // unsupported[0]

  exec_req_t    opcode_q[$];
  exec_result_t predicted_q[$];
  logic [7:0]   legal_ops[$];
  exec_req_t    cur_req;
  regs_t        cpu_regs = REGS_RESET;
  exec_result_t want;
  exec_result_t probe;
  bit           drv_busy;
  bit           calm = 1'b0;
  bit           hold_done = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  results_seen = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  cyc = 0;
  int unsigned  n_errors = 0;

  cpu_8bit_decode_execute_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] flag_zn(logic [7:0] p, logic [7:0] v);
    p[PB_Z] = (v == 8'h00);
    p[PB_N] = v[7];
    return p;
  endfunction

  function automatic regs_t add_to_a(regs_t r, logic [7:0] m);
    logic [8:0] sum;
    logic [7:0] res;
    sum = {1'b0, r.a} + {1'b0, m} + {8'h00, r.p[PB_C]};
    res = sum[7:0];
    r.p[PB_C] = sum[8];
    r.p[PB_V] = ~(r.a[7] ^ m[7]) & (r.a[7] ^ res[7]);
    r.a = res;
    r.p = flag_zn(r.p, res);
    return r;
  endfunction

  function automatic logic [7:0] cmp_flags(logic [7:0] p, logic [7:0] rv, logic [7:0] m);
    logic [7:0] diff;
    diff = rv - m;
    p[PB_C] = (rv >= m);
    return flag_zn(p, diff);
  endfunction

  // returns {new status, shifted byte}
  function automatic logic [15:0] shift_byte(logic [2:0] kind, logic [7:0] v, logic [7:0] p);
    logic [7:0] res;
    case (kind)
      RMW_ASL: res = {v[6:0], 1'b0};
      RMW_ROL: res = {v[6:0], p[PB_C]};
      RMW_LSR: res = {1'b0, v[7:1]};
      default: res = {p[PB_C], v[7:1]};
    endcase
    p[PB_C] = (kind == RMW_ASL || kind == RMW_ROL) ? v[7] : v[0];
    p = flag_zn(p, res);
    return {p, res};
  endfunction

  function automatic exec_result_t execute_opcode(regs_t r, logic [7:0] op, logic [7:0] m,
                                                  logic [7:0] sb);
    exec_result_t e;
    logic [2:0]   aaa;
    logic [2:0]   bbb;
    logic [7:0]   t;
    logic         hit;
    e = '0;
    aaa = op[7:5];
    bbb = op[4:2];
    case (op[1:0])
      CC_ALU: begin
        case (aaa)
          ALU_ORA: begin r.a = r.a | m; r.p = flag_zn(r.p, r.a); end
          ALU_AND: begin r.a = r.a & m; r.p = flag_zn(r.p, r.a); end
          ALU_EOR: begin r.a = r.a ^ m; r.p = flag_zn(r.p, r.a); end
          ALU_ADC: r = add_to_a(r, m);
          ALU_STA: begin
            if (bbb == BBB_ALU_IMM) begin
              e.fx.bad = 1'b1;
            end else begin
              e.fx.wd = r.a;
              e.fx.we = 1'b1;
            end
          end
          ALU_LDA: begin r.a = m; r.p = flag_zn(r.p, r.a); end
          ALU_CMP: r.p = cmp_flags(r.p, r.a, m);
          default: r = add_to_a(r, ~m);
        endcase
      end
      CC_RMW: begin
        if (aaa <= RMW_ROR) begin
          if (bbb[0]) begin
            {r.p, e.fx.wd} = shift_byte(aaa, m, r.p);
            e.fx.we = 1'b1;
          end else if (bbb == BBB_IMP) begin
            {r.p, r.a} = shift_byte(aaa, r.a, r.p);
          end else begin
            e.fx.bad = 1'b1;
          end
        end else begin
          case (aaa)
            RMW_STX: begin
              if (bbb == BBB_ZP || bbb == BBB_ABS || bbb == BBB_ZPX) begin
                e.fx.wd = r.x;
                e.fx.we = 1'b1;
              end else if (bbb == BBB_IMP) begin
                r.a = r.x;
                r.p = flag_zn(r.p, r.a);
              end else if (bbb == BBB_FLAG) begin
                r.sp = r.x;
              end else begin
                e.fx.bad = 1'b1;
              end
            end
            RMW_LDX: begin
              if (bbb == BBB_IMM || bbb[0]) begin
                r.x = m;
                r.p = flag_zn(r.p, r.x);
              end else if (bbb == BBB_IMP) begin
                r.x = r.a;
                r.p = flag_zn(r.p, r.x);
              end else if (bbb == BBB_FLAG) begin
                r.x = r.sp;
                r.p = flag_zn(r.p, r.x);
              end else begin
                e.fx.bad = 1'b1;
              end
            end
            default: begin
              if (bbb[0]) begin
                e.fx.wd = (aaa == RMW_DEC) ? m - 8'd1 : m + 8'd1;
                e.fx.we = 1'b1;
                r.p = flag_zn(r.p, e.fx.wd);
              end else if (bbb == BBB_IMP) begin
                if (aaa == RMW_DEC) begin
                  r.x = r.x - 8'd1;
                  r.p = flag_zn(r.p, r.x);
                end
              end else begin
                e.fx.bad = 1'b1;
              end
            end
          endcase
        end
      end
      CC_CTL: begin
        if (bbb == BBB_BRANCH) begin
          case (aaa[2:1])
            BRS_N:   hit = r.p[PB_N];
            BRS_V:   hit = r.p[PB_V];
            BRS_C:   hit = r.p[PB_C];
            default: hit = r.p[PB_Z];
          endcase
          e.fx.br = (hit == aaa[0]);
        end else if (bbb == BBB_IMP) begin
          case (aaa)
            IMP_PHP: begin
              t = r.p;
              t[PB_B] = 1'b1;
              t[PB_U] = 1'b1;
              e.fx.pd = t;
              e.fx.pe = 1'b1;
              r.sp = r.sp - 8'd1;
            end
            IMP_PLP: begin
              t = sb;
              t[PB_B] = 1'b0;
              t[PB_U] = 1'b1;
              r.p = t;
              r.sp = r.sp + 8'd1;
            end
            IMP_PHA: begin
              e.fx.pd = r.a;
              e.fx.pe = 1'b1;
              r.sp = r.sp - 8'd1;
            end
            IMP_PLA: begin
              r.a = sb;
              r.p = flag_zn(r.p, r.a);
              r.sp = r.sp + 8'd1;
            end
            IMP_DEY: begin r.y = r.y - 8'd1; r.p = flag_zn(r.p, r.y); end
            IMP_TAY: begin r.y = r.a; r.p = flag_zn(r.p, r.y); end
            IMP_INY: begin r.y = r.y + 8'd1; r.p = flag_zn(r.p, r.y); end
            default: begin r.x = r.x + 8'd1; r.p = flag_zn(r.p, r.x); end
          endcase
        end else if (bbb == BBB_FLAG) begin
          case (aaa)
            FLG_CLC: r.p[PB_C] = 1'b0;
            FLG_SEC: r.p[PB_C] = 1'b1;
            FLG_CLI: r.p[PB_I] = 1'b0;
            FLG_SEI: r.p[PB_I] = 1'b1;
            FLG_TYA: begin r.a = r.y; r.p = flag_zn(r.p, r.a); end
            FLG_CLV: r.p[PB_V] = 1'b0;
            FLG_CLD: r.p[PB_D] = 1'b0;
            default: r.p[PB_D] = 1'b1;
          endcase
        end else if (aaa == CTL_BIT && (bbb == BBB_ZP || bbb == BBB_ABS)) begin
          r.p[PB_Z] = ((r.a & m) == 8'h00);
          r.p[PB_V] = m[6];
          r.p[PB_N] = m[7];
        end else if (aaa == CTL_STY && (bbb == BBB_ZP || bbb == BBB_ABS || bbb == BBB_ZPX)) begin
          e.fx.wd = r.y;
          e.fx.we = 1'b1;
        end else if (aaa == CTL_LDY && (bbb == BBB_IMM || bbb[0])) begin
          r.y = m;
          r.p = flag_zn(r.p, r.y);
        end else if (aaa == CTL_CPY && (bbb == BBB_IMM || bbb == BBB_ZP || bbb == BBB_ABS)) begin
          r.p = cmp_flags(r.p, r.y, m);
        end else if (aaa == CTL_CPX && (bbb == BBB_IMM || bbb == BBB_ZP || bbb == BBB_ABS)) begin
          r.p = cmp_flags(r.p, r.x, m);
        end else begin
          e.fx.bad = 1'b1;
        end
      end
      default: e.fx.bad = 1'b1;
    endcase
    e.rg = r;
    return e;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [6];
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_req(logic [7:0] op, logic [7:0] m, logic [7:0] sb, bit drain);
    exec_req_t q;
    q.op = op;
    q.m = m;
    q.sb = sb;
    q.drain = drain;
    opcode_q.push_back(q);
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %02h, got %02h", name, want_v, got_v);
      n_errors++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      gap_left = 0;
    end else begin
      drv_busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        probe = execute_opcode(cpu_regs, cur_req.op, cur_req.m, cur_req.sb);
        cpu_regs = probe.rg;
        predicted_q.push_back(probe);
        drv_busy = 1'b0;
        gap_left = calm ? 0 : pick_gap();
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (opcode_q.size() > 0 &&
                     !(opcode_q[0].drain && predicted_q.size() != 0)) begin
          cur_req = opcode_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      s_axis_tvalid <= drv_busy;
      s_axis_tdata <= {cur_req.sb, cur_req.m};
      s_axis_tuser <= cur_req.op;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (predicted_q.size() == 0) begin
          $error("result with no pending request");
          n_errors++;
        end else begin
          want = predicted_q.pop_front();
          check_field("write_data", want.fx.wd, m_axis_tdata[7:0]);
          check_field("write_enable", {7'd0, want.fx.we}, {7'd0, m_axis_tdata[8]});
          check_field("push_data", want.fx.pd, m_axis_tdata[16:9]);
          check_field("push_enable", {7'd0, want.fx.pe}, {7'd0, m_axis_tdata[17]});
          check_field("branch_taken", {7'd0, want.fx.br}, {7'd0, m_axis_tdata[18]});
          check_field("acc_out", want.rg.a, m_axis_tdata[26:19]);
          check_field("xreg_out", want.rg.x, m_axis_tdata[34:27]);
          check_field("yreg_out", want.rg.y, m_axis_tdata[42:35]);
          check_field("sp_out", want.rg.sp, m_axis_tdata[50:43]);
          check_field("status_out", want.rg.p, m_axis_tdata[58:51]);
          check_field("unsupported", {7'd0, want.fx.bad}, {7'd0, m_axis_tuser});
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // watchdog and idle-mode selection
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      if (cyc % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("cpu_8bit_decode_execute_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      probe = execute_opcode(REGS_RESET, i[7:0], 8'h00, 8'h00);
      if (!probe.fx.bad) legal_ops.push_back(i[7:0]);
    end

    queue_req({ALU_LDA, BBB_ALU_IMM, CC_ALU}, 8'h7F, 8'h00, 1'b0);
    queue_req({ALU_ADC, BBB_ALU_IMM, CC_ALU}, 8'h01, 8'hFF, 1'b0);
    queue_req({ALU_ADC, BBB_ALU_IMM, CC_ALU}, 8'hFF, 8'h00, 1'b0);
    queue_req({FLG_SED, BBB_FLAG, CC_CTL}, 8'h00, 8'h00, 1'b0);
    queue_req({ALU_SBC, BBB_ALU_IMM, CC_ALU}, 8'h80, 8'h00, 1'b0);
    queue_req({ALU_CMP, BBB_ALU_IMM, CC_ALU}, 8'hFF, 8'h00, 1'b0);
    queue_req({BR_ON_V_SET, BBB_BRANCH, CC_CTL}, 8'h00, 8'h00, 1'b0);
    queue_req({BR_ON_V_CLEAR, BBB_BRANCH, CC_CTL}, 8'h00, 8'h00, 1'b0);
    queue_req({RMW_ROR, BBB_IMP, CC_RMW}, 8'h00, 8'h00, 1'b0);
    queue_req({RMW_INC, BBB_ZP, CC_RMW}, 8'hFF, 8'h00, 1'b0);
    queue_req({RMW_DEC, BBB_ZP, CC_RMW}, 8'h00, 8'h00, 1'b0);
    queue_req({IMP_PHP, BBB_IMP, CC_CTL}, 8'h00, 8'h00, 1'b0);
    queue_req({IMP_PLP, BBB_IMP, CC_CTL}, 8'h00, 8'hFF, 1'b0);
    queue_req({IMP_PLA, BBB_IMP, CC_CTL}, 8'hFF, 8'h00, 1'b0);
    queue_req({RMW_LDX, BBB_IMM, CC_RMW}, 8'h00, 8'h00, 1'b0);
    queue_req({RMW_STX, BBB_FLAG, CC_RMW}, 8'h00, 8'h00, 1'b0);
    queue_req({IMP_PHA, BBB_IMP, CC_CTL}, 8'h00, 8'h00, 1'b0);
    queue_req({RMW_LDX, BBB_FLAG, CC_RMW}, 8'h00, 8'h00, 1'b0);
    queue_req({RMW_STX, BBB_FLAG, CC_RMW}, 8'h00, 8'h00, 1'b0);
    queue_req({IMP_PLA, BBB_IMP, CC_CTL}, 8'h00, 8'h80, 1'b0);
    queue_req(OPC_BRK, 8'h00, 8'h00, 1'b0);
    queue_req(OPC_JMP_ABS, 8'h00, 8'h00, 1'b0);
    queue_req({ALU_STA, BBB_ALU_IMM, CC_ALU}, 8'h00, 8'h00, 1'b0);
    queue_req({ALU_SBC, BBB_ABS_X, CC_ILL}, 8'hFF, 8'hFF, 1'b0);
    queue_req({CTL_BIT, BBB_ABS, CC_CTL}, 8'hC0, 8'h00, 1'b0);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_req(legal_ops[$urandom_range(0, legal_ops.size() - 1)], pick_byte(),
                  pick_byte(), i == DRAIN_AT);
      end else begin
        queue_req(8'($urandom_range(0, 255)), pick_byte(), pick_byte(), i == DRAIN_AT);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (opcode_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && predicted_q.size() == 0) begin
      $display("cpu_8bit_decode_execute_unit verification clean");
    end else begin
      $display("cpu_8bit_decode_execute_unit verification failed");
    end
    $finish;
  end

endmodule
